// ===== hdl/ucs_pkg.sv =====
// package for the url component splitter: payload types, codes and scheme matcher
`default_nettype none

package ucs_pkg;

  localparam int MAX_URL_LEN_DEFAULT = 4096;
  localparam int POS_W = 13;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    pos_t        scheme_len;
    pos_t        host_stop;
    logic [15:0] port_value;
    logic [15:0] effective_port;
    pos_t        path_begin;
    pos_t        path_finish;
    pos_t        query_begin;
    pos_t        query_finish;
    pos_t        fragment_begin;
    logic [2:0]  present_mask;
    pos_t        url_length;
  } result_item_t;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SCHEME = 3'd1;
  localparam logic [2:0] ST_NO_REST   = 3'd2;
  localparam logic [2:0] ST_BAD_PORT  = 3'd3;
  localparam logic [2:0] ST_NO_HOST   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  // "://" tracking
  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_COLON = 2'd1;
  localparam logic [1:0] SEP_SLASH = 2'd2;

  // scheme class matcher codes
  localparam logic [3:0] CLS_START = 4'd0;
  localparam logic [3:0] CLS_H     = 4'd1;
  localparam logic [3:0] CLS_HT    = 4'd2;
  localparam logic [3:0] CLS_HTT   = 4'd3;
  localparam logic [3:0] CLS_HTTP  = 4'd4;
  localparam logic [3:0] CLS_HTTPS = 4'd5;
  localparam logic [3:0] CLS_W     = 4'd6;
  localparam logic [3:0] CLS_WS    = 4'd7;
  localparam logic [3:0] CLS_WSS   = 4'd8;
  localparam logic [3:0] CLS_DEAD  = 4'd15;

  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [16:0] PORT_SAT   = 17'd65536;

  // characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_W     = 8'h77;

  function automatic logic [3:0] class_next(input logic [3:0] s, input logic [7:0] c);
    logic [7:0] lc;
    logic [3:0] r;
    lc = c;
    if (c >= CH_UA && c <= CH_UZ) lc = c + 8'd32;
    r = CLS_DEAD;
    case (s)
      CLS_START: begin
        if (lc == CH_H) r = CLS_H;
        else if (lc == CH_W) r = CLS_W;
      end
      CLS_H:    if (lc == CH_T) r = CLS_HT;
      CLS_HT:   if (lc == CH_T) r = CLS_HTT;
      CLS_HTT:  if (lc == CH_P) r = CLS_HTTP;
      CLS_HTTP: if (lc == CH_S) r = CLS_HTTPS;
      CLS_W:    if (lc == CH_S) r = CLS_WS;
      CLS_WS:   if (lc == CH_S) r = CLS_WSS;
      default:  r = CLS_DEAD;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] known_port(input logic [3:0] cls);
    logic [15:0] r;
    case (cls)
      CLS_HTTPS, CLS_WSS: r = PORT_HTTPS;
      CLS_HTTP, CLS_WS:   r = PORT_HTTP;
      default:            r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/url_component_splitter_unit.sv =====
// top level of the url component splitter
`default_nettype none

// url component splitter: takes a url one byte per transaction on the byte
// channel (is_last marks the final byte) and gives one result transaction per
// url with status, scheme length, host end, port, effective port and the
// path, query and fragment offsets. throughput is one byte per cycle when no
// byte is stalled: a byte sits in the input register, the running trackers
// (scheme match, separator positions, bracket flags, port accumulator) update
// from it and on the last byte the finished result is loaded into the result
// register at the same edge at which that byte leaves the input register.
// the only stall is a last byte whose result would overwrite a result that
// has not yet been taken. bytes beyond MAX_URL_LEN are counted as overlong and
// not examined; offsets are reported modulo 2**13.
module url_component_splitter_unit #(
  parameter int MAX_URL_LEN = ucs_pkg::MAX_URL_LEN_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_ready,
  input  wire ucs_pkg::byte_item_t  byte_data,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output ucs_pkg::result_item_t     result_data
);

  // position width holds 0..MAX_URL_LEN, length width holds MAX_URL_LEN + 1
  localparam int PW = $clog2(MAX_URL_LEN + 1);
  localparam int LW = $clog2(MAX_URL_LEN + 2);

  // input register
  logic                byte_q_valid;
  ucs_pkg::byte_item_t byte_q;
  logic                go;
  logic                go_last;

  // running trackers
  logic [PW-1:0] byte_position, byte_position_next;
  logic          overlong, overlong_next;
  logic [1:0]    separator_match, separator_match_next;
  logic [PW-1:0] scheme_colon_pos, scheme_colon_pos_next;
  logic          scheme_found, scheme_found_next;
  logic          slash_seen, slash_seen_next;
  logic [PW-1:0] slash_pos, slash_pos_next;
  logic          question_seen, question_seen_next;
  logic [PW-1:0] question_pos, question_pos_next;
  logic          hash_seen, hash_seen_next;
  logic [PW-1:0] hash_pos, hash_pos_next;
  logic          colon_seen, colon_seen_next;
  logic [PW-1:0] colon_pos, colon_pos_next;
  logic          open_seen, open_seen_next;
  logic          close_seen, close_seen_next;
  logic [PW-1:0] close_pos, close_pos_next;
  logic [16:0]   port_acc, port_acc_next;
  logic          port_digits, port_digits_next;
  logic          port_bad, port_bad_next;
  logic [3:0]    class_state, class_state_next;
  logic [3:0]    class_at_colon, class_at_colon_next;

  logic [7:0]  c;
  logic [19:0] acc_wide;

  // result computation
  ucs_pkg::result_item_t res;
  logic [LW-1:0] len, hs, he, pe, qe, hash_end;
  logic [LW-1:0] slash_l, question_l, hash_l, colon_l, close_l, scheme_l;
  logic          parse;
  logic [2:0]    st;
  logic [15:0]   port;

  // a byte moves on unless it is a last byte blocked by an untaken result
  assign go         = byte_q_valid && (!byte_q.is_last || !result_valid || result_ready);
  assign go_last    = go && byte_q.is_last;
  assign byte_ready = !byte_q_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      byte_q_valid <= 1'b1;
    end else if (go) begin
      byte_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      byte_q <= byte_data;
    end
  end

  // tracker update for the byte in the input register
  always_comb begin
    byte_position_next    = byte_position;
    overlong_next         = overlong;
    separator_match_next  = separator_match;
    scheme_colon_pos_next = scheme_colon_pos;
    scheme_found_next     = scheme_found;
    slash_seen_next       = slash_seen;
    slash_pos_next        = slash_pos;
    question_seen_next    = question_seen;
    question_pos_next     = question_pos;
    hash_seen_next        = hash_seen;
    hash_pos_next         = hash_pos;
    colon_seen_next       = colon_seen;
    colon_pos_next        = colon_pos;
    open_seen_next        = open_seen;
    close_seen_next       = close_seen;
    close_pos_next        = close_pos;
    port_acc_next         = port_acc;
    port_digits_next      = port_digits;
    port_bad_next         = port_bad;
    class_state_next      = class_state;
    class_at_colon_next   = class_at_colon;
    c                     = byte_q.char_byte;
    acc_wide              = (20'(port_acc) << 3) + (20'(port_acc) << 1) + 20'(c - ucs_pkg::CH_0);

    if (byte_position == PW'(MAX_URL_LEN)) begin
      // past the limit: count it, look no further
      overlong_next = 1'b1;
    end else begin
      byte_position_next = byte_position + 1'b1;
      if (!scheme_found) begin
        // scheme region: match "://" and classify the scheme text
        if (c == ucs_pkg::CH_COLON) class_at_colon_next = class_state;
        class_state_next = ucs_pkg::class_next(class_state, c);
        if (c == ucs_pkg::CH_COLON) begin
          separator_match_next = ucs_pkg::SEP_COLON;
        end else if (c == ucs_pkg::CH_SLASH && separator_match == ucs_pkg::SEP_COLON) begin
          separator_match_next = ucs_pkg::SEP_SLASH;
        end else if (c == ucs_pkg::CH_SLASH && separator_match == ucs_pkg::SEP_SLASH) begin
          scheme_found_next     = 1'b1;
          scheme_colon_pos_next = byte_position - PW'(2);
          separator_match_next  = ucs_pkg::SEP_NONE;
        end else begin
          separator_match_next = ucs_pkg::SEP_NONE;
        end
      end else if (c inside {ucs_pkg::CH_SLASH, ucs_pkg::CH_QUEST, ucs_pkg::CH_HASH}) begin
        // first occurrence of each separator
        if (c == ucs_pkg::CH_SLASH && !slash_seen) begin
          slash_seen_next = 1'b1;
          slash_pos_next  = byte_position;
        end
        if (c == ucs_pkg::CH_QUEST && !question_seen) begin
          question_seen_next = 1'b1;
          question_pos_next  = byte_position;
        end
        if (c == ucs_pkg::CH_HASH && !hash_seen) begin
          hash_seen_next = 1'b1;
          hash_pos_next  = byte_position;
        end
      end else if (!(slash_seen || question_seen || hash_seen)) begin
        // host region: brackets, last colon, port digits
        if (c == ucs_pkg::CH_OPEN) open_seen_next = 1'b1;
        if (c == ucs_pkg::CH_CLOSE && !close_seen) begin
          close_seen_next = 1'b1;
          close_pos_next  = byte_position;
        end
        if (c == ucs_pkg::CH_COLON) begin
          colon_seen_next  = 1'b1;
          colon_pos_next   = byte_position;
          port_acc_next    = '0;
          port_digits_next = 1'b0;
          port_bad_next    = 1'b0;
        end else if (colon_seen) begin
          if (c inside {[ucs_pkg::CH_0:ucs_pkg::CH_9]}) begin
            port_acc_next    = (acc_wide > 20'(ucs_pkg::PORT_MAX)) ? ucs_pkg::PORT_SAT
                                                                  : acc_wide[16:0];
            port_digits_next = 1'b1;
          end else begin
            port_bad_next = 1'b1;
          end
        end
      end
    end
  end

  // result from the updated trackers
  always_comb begin
    slash_l    = LW'(slash_pos_next);
    question_l = LW'(question_pos_next);
    hash_l     = LW'(hash_pos_next);
    colon_l    = LW'(colon_pos_next);
    close_l    = LW'(close_pos_next);
    scheme_l   = LW'(scheme_colon_pos_next);
    len        = overlong_next ? (LW'(MAX_URL_LEN) + 1'b1) : (LW'(byte_position) + 1'b1);
    hs         = scheme_l + LW'(3);

    // host ends at the earliest separator
    he = len;
    if (slash_seen_next && slash_l < he) he = slash_l;
    if (question_seen_next && question_l < he) he = question_l;
    if (hash_seen_next && hash_l < he) he = hash_l;

    // a port is parsed from the last colon unless it sits inside brackets
    parse = colon_seen_next && colon_l > hs &&
            (!open_seen_next || (close_seen_next && colon_l > close_l));

    // path runs to the next separator, or to the end when that lies before it
    pe = len;
    if (question_seen_next && question_l < pe) pe = question_l;
    if (hash_seen_next && hash_l < pe) pe = hash_l;
    if (pe < slash_l) pe = len;

    qe = (hash_seen_next && hash_l > question_l) ? hash_l : len;
    hash_end = hash_l + 1'b1;

    st   = ucs_pkg::ST_OK;
    port = '0;
    if (overlong_next) begin
      st = ucs_pkg::ST_TOO_LONG;
    end else if (!scheme_found_next || scheme_colon_pos_next == '0) begin
      st = ucs_pkg::ST_NO_SCHEME;
    end else if (hs >= len) begin
      st = ucs_pkg::ST_NO_REST;
    end else if (parse && (!port_digits_next || port_bad_next ||
                           port_acc_next > ucs_pkg::PORT_MAX)) begin
      st = ucs_pkg::ST_BAD_PORT;
    end else if (he == hs) begin
      st = ucs_pkg::ST_NO_HOST;
    end else if (parse) begin
      port = port_acc_next[15:0];
    end

    res            = '0;
    res.status     = st;
    res.url_length = ucs_pkg::pos_t'(len);
    if (st == ucs_pkg::ST_OK) begin
      res.scheme_len     = ucs_pkg::pos_t'(scheme_l);
      res.host_stop      = parse ? ucs_pkg::pos_t'(colon_l) : ucs_pkg::pos_t'(he);
      res.port_value     = port;
      res.effective_port = (port != '0) ? port : ucs_pkg::known_port(class_at_colon_next);
      if (slash_seen_next) begin
        res.path_begin      = ucs_pkg::pos_t'(slash_l);
        res.path_finish     = ucs_pkg::pos_t'(pe);
        res.present_mask[0] = 1'b1;
      end
      if (question_seen_next) begin
        res.query_begin     = ucs_pkg::pos_t'(question_l + 1'b1);
        res.query_finish    = ucs_pkg::pos_t'(qe);
        res.present_mask[1] = 1'b1;
      end
      // fragment counts only when a byte follows the hash
      if (hash_seen_next && hash_end < len) begin
        res.fragment_begin  = ucs_pkg::pos_t'(hash_end);
        res.present_mask[2] = 1'b1;
      end
    end
  end

  // tracker registers, cleared after each url
  always_ff @(posedge clk) begin
    if (rst || go_last) begin
      byte_position    <= '0;
      overlong         <= 1'b0;
      separator_match  <= ucs_pkg::SEP_NONE;
      scheme_colon_pos <= '0;
      scheme_found     <= 1'b0;
      slash_seen       <= 1'b0;
      slash_pos        <= '0;
      question_seen    <= 1'b0;
      question_pos     <= '0;
      hash_seen        <= 1'b0;
      hash_pos         <= '0;
      colon_seen       <= 1'b0;
      colon_pos        <= '0;
      open_seen        <= 1'b0;
      close_seen       <= 1'b0;
      close_pos        <= '0;
      port_acc         <= '0;
      port_digits      <= 1'b0;
      port_bad         <= 1'b0;
      class_state      <= ucs_pkg::CLS_START;
      class_at_colon   <= ucs_pkg::CLS_DEAD;
    end else if (go) begin
      byte_position    <= byte_position_next;
      overlong         <= overlong_next;
      separator_match  <= separator_match_next;
      scheme_colon_pos <= scheme_colon_pos_next;
      scheme_found     <= scheme_found_next;
      slash_seen       <= slash_seen_next;
      slash_pos        <= slash_pos_next;
      question_seen    <= question_seen_next;
      question_pos     <= question_pos_next;
      hash_seen        <= hash_seen_next;
      hash_pos         <= hash_pos_next;
      colon_seen       <= colon_seen_next;
      colon_pos        <= colon_pos_next;
      open_seen        <= open_seen_next;
      close_seen       <= close_seen_next;
      close_pos        <= close_pos_next;
      port_acc         <= port_acc_next;
      port_digits      <= port_digits_next;
      port_bad         <= port_bad_next;
      class_state      <= class_state_next;
      class_at_colon   <= class_at_colon_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go_last) begin
      result_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ucs_checker.sv =====
// port checker for the url component splitter and its bind
`default_nettype none

module ucs_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  result_valid,
  input wire logic                  result_ready,
  input wire ucs_pkg::result_item_t result_data
);

  // a held result stays put until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // error results carry no offsets, flags or ports
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != ucs_pkg::ST_OK |->
      result_data.scheme_len == '0 && result_data.host_stop == '0 &&
      result_data.port_value == '0 && result_data.effective_port == '0 &&
      result_data.present_mask == '0)
    else $error("error result carries fields");

  // an explicit port wins over the scheme default
  a_port_wins: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.port_value != '0 |->
      result_data.effective_port == result_data.port_value)
    else $error("effective port differs from explicit port");

  // absent segments report zero offsets
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result_data.present_mask[0] ||
        (result_data.path_begin == '0 && result_data.path_finish == '0)) &&
      (result_data.present_mask[1] ||
        (result_data.query_begin == '0 && result_data.query_finish == '0)) &&
      (result_data.present_mask[2] || result_data.fragment_begin == '0))
    else $error("absent segment has offsets");

endmodule

bind url_component_splitter_unit ucs_checker u_ucs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);

`default_nettype wire
